>>> rtl/rlbe_pkg.sv
`timescale 1ns / 1ps

package rlbe_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned FIELD_LANES       = 4;
  localparam int unsigned LANE_IDX_W        = 2;
  localparam int unsigned COUNT_W           = 3;
  localparam int unsigned M_TDATA_W         = 40;
  localparam int unsigned MAX_BLOCK_DEFAULT = 128;
  localparam int unsigned OUT_LANES_DEFAULT = 4;

  localparam logic [BYTE_W-1:0] END_MARK = 8'd128;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    DP_HOLD,
    DP_STEP,
    DP_FIN_PUSH,
    DP_FIN_REP,
    DP_LIT_FIRST,
    DP_LIT_NEXT,
    DP_LIT_DONE,
    DP_CLEAR
  } dp_cmd_e;

  // source of the code byte handed to the packer
  typedef enum logic [2:0] {
    SEL_LIT_HDR,
    SEL_LIT_DATA,
    SEL_REP_CODE,
    SEL_REP_BYTE,
    SEL_END
  } byte_sel_e;

  typedef struct packed {
    dp_cmd_e   cmd;
    byte_sel_e sel;
  } dp_ctrl_t;

  typedef struct packed {
    logic step_lit;   // item about to be taken flushes the literal store
    logic step_rep;   // item about to be taken closes a repeat block
    logic plan_rep;   // taken item left a repeat block to send
    logic fin;        // taken item was the last of its stream
    logic fin_push;   // end of stream: held byte goes out as a literal
    logic fin_rep;    // end of stream: pending run goes out as a repeat block
    logic lit_last;   // literal readout is at its final byte
  } dp_stat_t;

  typedef struct packed {
    logic push;
    logic close;
    logic last;
  } pk_ctrl_t;

endpackage

>>> rtl/rlbe_dp.sv
`timescale 1ns / 1ps

module rlbe_dp #(
  parameter int unsigned MAX_BLOCK = rlbe_pkg::MAX_BLOCK_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rlbe_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                        final_input_i,
  input  rlbe_pkg::dp_ctrl_t          ctrl_i,
  output rlbe_pkg::dp_stat_t          stat_o,
  output logic [rlbe_pkg::BYTE_W-1:0] byte_o
);

  localparam int unsigned AW = $clog2(MAX_BLOCK);
  localparam int unsigned CW = $clog2(MAX_BLOCK + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RUN,
    MODE_CONT
  } mode_e;

  mode_e                        mode_q, step_mode;
  logic [rlbe_pkg::BYTE_W-1:0]  held_q, step_held;
  logic [CW-1:0]                rc_q, step_rc, rc_inc;
  logic [CW-1:0]                fill_q, step_fill;
  logic                         fin_q;
  logic                         plan_rep_q;
  logic [rlbe_pkg::BYTE_W-1:0]  rep_code_q, rep_byte_q, step_code;
  logic [AW-1:0]                idx_q;
  logic [AW:0]                  idx_ext;
  logic                         step_lit, step_rep, step_push;

  logic [rlbe_pkg::BYTE_W-1:0]  mem [MAX_BLOCK];
  logic [rlbe_pkg::BYTE_W-1:0]  rdata_q;
  logic                         we, re;
  logic [AW-1:0]                raddr;

  // length byte of a repeat block: 257 - count, kept to 8 bits
  function automatic logic [rlbe_pkg::BYTE_W-1:0] rep_code(input logic [CW-1:0] n);
    logic [8:0] v;
    v = 9'd257 - 9'(n);
    return v[7:0];
  endfunction

  // state update for the item on the input
  always_comb begin
    step_lit  = 1'b0;
    step_rep  = 1'b0;
    step_push = 1'b0;
    step_code = rep_code(rc_q);
    step_mode = mode_q;
    step_held = held_q;
    step_rc   = rc_q;
    step_fill = fill_q;
    rc_inc    = rc_q + CW'(1);
    case (mode_q)
      MODE_RUN: begin
        if (data_byte_i == held_q) begin
          if (rc_q == CW'(1) && fill_q != '0) begin
            step_lit = 1'b1;
          end
          if (rc_inc >= CW'(MAX_BLOCK)) begin
            step_rep  = 1'b1;
            step_code = rep_code(rc_inc);
            step_mode = MODE_CONT;
            step_rc   = '0;
          end else begin
            step_rc = rc_inc;
          end
        end else begin
          if (rc_q <= CW'(1)) begin
            step_push = 1'b1;
            step_fill = fill_q + CW'(1);
            if (step_fill >= CW'(MAX_BLOCK)) begin
              step_lit = 1'b1;
            end
          end else begin
            step_rep = 1'b1;
          end
          step_mode = MODE_RUN;
          step_held = data_byte_i;
          step_rc   = CW'(1);
        end
      end
      MODE_CONT: begin
        if (data_byte_i == held_q) begin
          if (rc_inc >= CW'(MAX_BLOCK)) begin
            step_rep  = 1'b1;
            step_code = rep_code(rc_inc);
            step_rc   = '0;
          end else begin
            step_rc = rc_inc;
          end
        end else begin
          step_rep  = (rc_q != '0);
          step_fill = '0;
          step_mode = MODE_RUN;
          step_held = data_byte_i;
          step_rc   = CW'(1);
        end
      end
      default: begin
        step_fill = '0;
        step_mode = MODE_RUN;
        step_held = data_byte_i;
        step_rc   = CW'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      held_q     <= '0;
      rc_q       <= '0;
      fill_q     <= '0;
      fin_q      <= 1'b0;
      plan_rep_q <= 1'b0;
      rep_code_q <= '0;
      rep_byte_q <= '0;
      idx_q      <= '0;
    end else begin
      case (ctrl_i.cmd)
        rlbe_pkg::DP_STEP: begin
          mode_q     <= step_mode;
          held_q     <= step_held;
          rc_q       <= step_rc;
          fill_q     <= step_fill;
          fin_q      <= final_input_i;
          plan_rep_q <= step_rep;
          if (step_rep) begin
            rep_code_q <= step_code;
            rep_byte_q <= held_q;
          end
        end
        rlbe_pkg::DP_FIN_PUSH: fill_q <= fill_q + CW'(1);
        rlbe_pkg::DP_FIN_REP: begin
          rep_code_q <= rep_code(rc_q);
          rep_byte_q <= held_q;
        end
        rlbe_pkg::DP_LIT_FIRST: idx_q <= '0;
        rlbe_pkg::DP_LIT_NEXT:  idx_q <= idx_q + AW'(1);
        rlbe_pkg::DP_LIT_DONE:  fill_q <= '0;
        rlbe_pkg::DP_CLEAR: begin
          mode_q     <= MODE_IDLE;
          held_q     <= '0;
          rc_q       <= '0;
          fill_q     <= '0;
          fin_q      <= 1'b0;
          plan_rep_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // literal store: one write port, one registered read port
  assign we    = (ctrl_i.cmd == rlbe_pkg::DP_STEP && step_push) ||
                 (ctrl_i.cmd == rlbe_pkg::DP_FIN_PUSH);
  assign re    = (ctrl_i.cmd == rlbe_pkg::DP_LIT_FIRST) ||
                 (ctrl_i.cmd == rlbe_pkg::DP_LIT_NEXT);
  assign raddr = (ctrl_i.cmd == rlbe_pkg::DP_LIT_FIRST) ? '0 : idx_q + AW'(1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[fill_q[AW-1:0]] <= held_q;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign idx_ext = {1'b0, idx_q} + (AW+1)'(1);

  always_comb begin
    stat_o.step_lit = step_lit;
    stat_o.step_rep = step_rep;
    stat_o.plan_rep = plan_rep_q;
    stat_o.fin      = fin_q;
    stat_o.fin_push = (mode_q == MODE_RUN) && (rc_q <= CW'(1));
    stat_o.fin_rep  = ((mode_q == MODE_RUN) && (rc_q > CW'(1))) ||
                      ((mode_q == MODE_CONT) && (rc_q != '0));
    stat_o.lit_last = (idx_ext == (AW+1)'(fill_q));
  end

  always_comb begin
    case (ctrl_i.sel)
      rlbe_pkg::SEL_LIT_HDR:  byte_o = rlbe_pkg::BYTE_W'(fill_q) - 8'd1;
      rlbe_pkg::SEL_LIT_DATA: byte_o = rdata_q;
      rlbe_pkg::SEL_REP_CODE: byte_o = rep_code_q;
      rlbe_pkg::SEL_REP_BYTE: byte_o = rep_byte_q;
      rlbe_pkg::SEL_END:      byte_o = rlbe_pkg::END_MARK;
      default:                byte_o = rlbe_pkg::END_MARK;
    endcase
  end

endmodule

>>> rtl/rlbe_pack.sv
`timescale 1ns / 1ps

module rlbe_pack #(
  parameter int unsigned LANES = rlbe_pkg::OUT_LANES_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rlbe_pkg::BYTE_W-1:0]    byte_i,
  input  rlbe_pkg::pk_ctrl_t             ctrl_i,
  output logic                           acc_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [rlbe_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic                           m_tlast_o
);

  localparam int unsigned NB  = rlbe_pkg::FIELD_LANES;
  localparam int unsigned BW  = rlbe_pkg::BYTE_W;
  localparam int unsigned CNW = rlbe_pkg::COUNT_W;
  localparam int unsigned PAD = rlbe_pkg::M_TDATA_W - NB * BW - CNW;

  logic [NB-1:0][BW-1:0] lane_q, lanes_n, word;
  logic [CNW-1:0]        cnt_q, new_cnt;
  logic [NB-1:0][BW-1:0] out_bytes_q;
  logic [CNW-1:0]        out_cnt_q;
  logic                  out_valid_q, out_last_q;
  logic                  emit, out_free;

  always_comb begin
    new_cnt = cnt_q + CNW'(ctrl_i.push);
    lanes_n = lane_q;
    if (ctrl_i.push) begin
      lanes_n[cnt_q[rlbe_pkg::LANE_IDX_W-1:0]] = byte_i;
    end
    for (int j = 0; j < NB; j++) begin
      word[j] = (CNW'(j) < new_cnt) ? lanes_n[j] : '0;
    end
    emit     = (ctrl_i.push && (ctrl_i.close || new_cnt == CNW'(LANES))) ||
               (!ctrl_i.push && ctrl_i.close && cnt_q != '0);
    out_free = !out_valid_q || m_tready_i;
    acc_o    = (ctrl_i.push || ctrl_i.close) && (!emit || out_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q      <= '0;
      cnt_q       <= '0;
      out_bytes_q <= '0;
      out_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (acc_o && emit) begin
      out_bytes_q <= word;
      out_cnt_q   <= new_cnt;
      out_last_q  <= ctrl_i.last;
      out_valid_q <= 1'b1;
      cnt_q       <= '0;
    end else begin
      if (acc_o && ctrl_i.push) begin
        lane_q <= lanes_n;
        cnt_q  <= new_cnt;
      end
      if (out_valid_q && m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {PAD'(0), out_cnt_q, out_bytes_q};

endmodule

>>> rtl/rlbe_ctrl.sv
`timescale 1ns / 1ps

module rlbe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               s_last_i,
  output logic               ready_o,
  input  rlbe_pkg::dp_stat_t stat_i,
  input  logic               acc_i,
  output rlbe_pkg::dp_ctrl_t dp_o,
  output rlbe_pkg::pk_ctrl_t pk_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIT_HDR,
    S_LIT_DATA,
    S_REP_CODE,
    S_REP_BYTE,
    S_FIN,
    S_END,
    S_CLOSE
  } state_e;

  state_e state_q, state_d;
  logic   fin_phase_q, fin_phase_d;

  assign ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    fin_phase_d = fin_phase_q;
    dp_o.cmd    = rlbe_pkg::DP_HOLD;
    dp_o.sel    = rlbe_pkg::SEL_LIT_HDR;
    pk_o        = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          dp_o.cmd    = rlbe_pkg::DP_STEP;
          fin_phase_d = 1'b0;
          if (stat_i.step_lit) begin
            state_d = S_LIT_HDR;
          end else if (stat_i.step_rep) begin
            state_d = S_REP_CODE;
          end else if (s_last_i) begin
            state_d = S_FIN;
          end
        end
      end
      S_LIT_HDR: begin
        dp_o.sel  = rlbe_pkg::SEL_LIT_HDR;
        pk_o.push = 1'b1;
        if (acc_i) begin
          dp_o.cmd = rlbe_pkg::DP_LIT_FIRST;
          state_d  = S_LIT_DATA;
        end
      end
      S_LIT_DATA: begin
        dp_o.sel  = rlbe_pkg::SEL_LIT_DATA;
        pk_o.push = 1'b1;
        if (acc_i) begin
          if (stat_i.lit_last) begin
            dp_o.cmd = rlbe_pkg::DP_LIT_DONE;
            if (fin_phase_q) begin
              state_d = S_END;
            end else if (stat_i.plan_rep) begin
              state_d = S_REP_CODE;
            end else if (stat_i.fin) begin
              state_d = S_FIN;
            end else begin
              state_d = S_CLOSE;
            end
          end else begin
            dp_o.cmd = rlbe_pkg::DP_LIT_NEXT;
          end
        end
      end
      S_REP_CODE: begin
        dp_o.sel  = rlbe_pkg::SEL_REP_CODE;
        pk_o.push = 1'b1;
        if (acc_i) begin
          state_d = S_REP_BYTE;
        end
      end
      S_REP_BYTE: begin
        dp_o.sel  = rlbe_pkg::SEL_REP_BYTE;
        pk_o.push = 1'b1;
        if (acc_i) begin
          if (fin_phase_q) begin
            state_d = S_END;
          end else if (stat_i.fin) begin
            state_d = S_FIN;
          end else begin
            state_d = S_CLOSE;
          end
        end
      end
      S_FIN: begin
        fin_phase_d = 1'b1;
        if (stat_i.fin_push) begin
          dp_o.cmd = rlbe_pkg::DP_FIN_PUSH;
          state_d  = S_LIT_HDR;
        end else if (stat_i.fin_rep) begin
          dp_o.cmd = rlbe_pkg::DP_FIN_REP;
          state_d  = S_REP_CODE;
        end else begin
          state_d = S_END;
        end
      end
      S_END: begin
        dp_o.sel   = rlbe_pkg::SEL_END;
        pk_o.push  = 1'b1;
        pk_o.close = 1'b1;
        pk_o.last  = 1'b1;
        if (acc_i) begin
          dp_o.cmd = rlbe_pkg::DP_CLEAR;
          state_d  = S_IDLE;
        end
      end
      S_CLOSE: begin
        pk_o.close = 1'b1;
        if (acc_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_phase_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_phase_q <= fin_phase_d;
    end
  end

endmodule

>>> rtl/run_length_byte_encoder.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit first)                        tlast          tuser
// s_axis   in   data_byte[7:0]                               final_input    -
// m_axis   out  code_byte_a..d[31:0], byte_count[34:32], 0s  end_of_output  -
//
// An item that produces no code bytes leaves the encoder idle; the next item is
// taken right after it. An item that produces code bytes pushes them to the packer
// one by one and then either closes the result or, on the last item of a stream,
// chooses the end-of-stream flush (the end marker then closes the result). A full
// literal block is its header and 128 bytes. The packer takes one code byte per
// cycle unless m_axis stalls it, and the literal store has a single read port.
// Reset (rst_ni low, asynchronous) empties the encoder and the output register.
// A stalled m_axis holds the encoder at the packer; input items wait in s_axis
// until the last result of the current item is packed.

module run_length_byte_encoder #(
  parameter int unsigned MAX_BLOCK = rlbe_pkg::MAX_BLOCK_DEFAULT,
  parameter int unsigned OUT_LANES = rlbe_pkg::OUT_LANES_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rlbe_pkg::BYTE_W-1:0]    s_axis_tdata,  // data_byte
  input  logic                           s_axis_tlast,  // final_input
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // code_byte_a, code_byte_b, code_byte_c, code_byte_d, byte_count, zero fill
  output logic [rlbe_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast   // end_of_output
);

  // the result carries four code bytes at most
  localparam int unsigned Lanes = (OUT_LANES > rlbe_pkg::FIELD_LANES) ?
                                  rlbe_pkg::FIELD_LANES :
                                  ((OUT_LANES < 1) ? 1 : OUT_LANES);

  rlbe_pkg::dp_ctrl_t          dp_ctrl;
  rlbe_pkg::dp_stat_t          dp_stat;
  rlbe_pkg::pk_ctrl_t          pk_ctrl;
  logic                        pk_acc;
  logic [rlbe_pkg::BYTE_W-1:0] code_byte;

  // sequence the code bytes of each item: literals, repeat, end of stream
  rlbe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .ready_o   (s_axis_tready),
    .stat_i    (dp_stat),
    .acc_i     (pk_acc),
    .dp_o      (dp_ctrl),
    .pk_o      (pk_ctrl)
  );

  // run and literal state, literal store, code byte selection
  rlbe_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (s_axis_tdata),
    .final_input_i (s_axis_tlast),
    .ctrl_i        (dp_ctrl),
    .stat_o        (dp_stat),
    .byte_o        (code_byte)
  );

  // gather code bytes into results and hold the output item
  rlbe_pack #(
    .LANES (Lanes)
  ) u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (code_byte),
    .ctrl_i     (pk_ctrl),
    .acc_o      (pk_acc),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned BLOCK_MAX   = rlbe_pkg::MAX_BLOCK_DEFAULT;
  localparam int unsigned LANES       =
    (rlbe_pkg::OUT_LANES_DEFAULT > rlbe_pkg::FIELD_LANES) ? rlbe_pkg::FIELD_LANES :
    ((rlbe_pkg::OUT_LANES_DEFAULT < 1) ? 1 : rlbe_pkg::OUT_LANES_DEFAULT);
  localparam int unsigned REPEAT_BASE = 257;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned REPORT_MAX  = 10;

  typedef logic [rlbe_pkg::BYTE_W-1:0] octet_t;

  // one result item as it leaves m_axis: tlast above the low 35 tdata bits
  typedef struct packed {
    logic                                                    last;
    logic [rlbe_pkg::COUNT_W-1:0]                            count;
    logic [rlbe_pkg::FIELD_LANES-1:0][rlbe_pkg::BYTE_W-1:0]  code;
  } code_word_t;

  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_GATHER,
    RUN_TAIL
  } run_state_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [rlbe_pkg::BYTE_W-1:0]    s_axis_tdata = '0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [rlbe_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  // encoder image kept by the bench
  run_state_e run_state;
  octet_t     run_byte;
  int         run_len;
  octet_t     lit_buf [BLOCK_MAX];
  int         lit_len;
  octet_t     code_bytes [$];

  code_word_t pending_words [$];
  octet_t     stream_q [$];
  int         mismatch_cnt = 0;

  bit src_jitter  = 1'b1;
  bit sink_jitter = 1'b1;
  bit hold_req    = 1'b0;

  run_length_byte_encoder #(
    .MAX_BLOCK(BLOCK_MAX),
    .OUT_LANES(rlbe_pkg::OUT_LANES_DEFAULT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- encoding
  function void put_code(input octet_t b);
    code_bytes.push_back(b);
  endfunction

  function void put_repeat(input int n);
    put_code(octet_t'(REPEAT_BASE - n));
    put_code(run_byte);
  endfunction

  function void flush_literals();
    if (lit_len == 0) return;
    put_code(octet_t'(lit_len - 1));
    for (int i = 0; i < lit_len; i++) put_code(lit_buf[i]);
    lit_len = 0;
  endfunction

  function void push_literal(input octet_t b);
    if (lit_len < BLOCK_MAX) begin
      lit_buf[lit_len] = b;
      lit_len++;
    end
    if (lit_len >= BLOCK_MAX) flush_literals();
  endfunction

  function void start_run(input octet_t b);
    run_state = RUN_GATHER;
    run_byte  = b;
    run_len   = 1;
  endfunction

  function void clear_encoder();
    run_state = RUN_IDLE;
    run_byte  = '0;
    run_len   = 0;
    lit_len   = 0;
  endfunction

  // work out the code bytes of one raw byte and split them into result words
  function void encode_byte(input octet_t x, input logic fin);
    int         pos;
    int         n;
    code_word_t w;
    code_bytes.delete();
    case (run_state)
      RUN_GATHER: begin
        if (x == run_byte) begin
          if (run_len == 1) flush_literals();
          run_len++;
          if (run_len >= BLOCK_MAX) begin
            put_repeat(run_len);
            run_state = RUN_TAIL;
            run_len   = 0;
          end
        end else begin
          if (run_len <= 1) push_literal(run_byte);
          else put_repeat(run_len);
          start_run(x);
        end
      end
      RUN_TAIL: begin
        if (x == run_byte) begin
          run_len++;
          if (run_len >= BLOCK_MAX) begin
            put_repeat(run_len);
            run_len = 0;
          end
        end else begin
          // a single leftover byte comes out as (0, byte)
          if (run_len != 0) put_repeat(run_len);
          lit_len = 0;
          start_run(x);
        end
      end
      default: begin
        lit_len = 0;
        start_run(x);
      end
    endcase

    if (fin) begin
      if (run_state == RUN_GATHER) begin
        if (run_len <= 1) begin
          push_literal(run_byte);
          flush_literals();
        end else begin
          put_repeat(run_len);
        end
      end else if (run_state == RUN_TAIL) begin
        if (run_len != 0) put_repeat(run_len);
      end
      put_code(rlbe_pkg::END_MARK);
      clear_encoder();
    end

    pos = 0;
    while (pos < code_bytes.size()) begin
      n = code_bytes.size() - pos;
      if (n > LANES) n = LANES;
      w = '0;
      for (int j = 0; j < n; j++) w.code[j] = code_bytes[pos+j];
      w.count = rlbe_pkg::COUNT_W'(n);
      pos += n;
      w.last = fin && (pos >= code_bytes.size());
      pending_words.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------- checking
  function void note_mismatch(input string what, input longint unsigned want,
                              input longint unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("tb: mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
  endfunction

  function void check_word(input code_word_t got);
    code_word_t want;
    if (pending_words.size() == 0) begin
      note_mismatch("result with none expected, word", 0, got);
      return;
    end
    want = pending_words.pop_front();
    for (int j = 0; j < rlbe_pkg::FIELD_LANES; j++)
      if (got.code[j] !== want.code[j])
        note_mismatch($sformatf("code byte %0d", j), want.code[j], got.code[j]);
    if (got.count !== want.count) note_mismatch("byte_count", want.count, got.count);
    if (got.last !== want.last) note_mismatch("end_of_output", want.last, got.last);
  endfunction

  // inputs are predicted before outputs are checked within the same edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      encode_byte(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      check_word({m_axis_tlast,
                  m_axis_tdata[rlbe_pkg::COUNT_W+rlbe_pkg::FIELD_LANES*rlbe_pkg::BYTE_W-1:0]});
  end

  // ------------------------------------------------------------------ sink
  initial begin : sink
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // long hold-off so the encoder backs up into s_axis
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (sink_jitter && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- source
  task automatic send_item(input octet_t data, input logic last);
    if (src_jitter && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      send_item(stream_q[i], i == stream_q.size() - 1);
  endtask

  // step past the edge of the last accept so its prediction is in place
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic octet_t fresh_byte();
    octet_t v;
    v = octet_t'($urandom_range(0, 255));
    if (stream_q.size() != 0 && v == stream_q[$]) v = v + 8'd1;
    return v;
  endfunction

  function void add_run(input octet_t v, input int n);
    repeat (n) stream_q.push_back(v);
  endfunction

  function void add_literals(input int n);
    repeat (n) stream_q.push_back(fresh_byte());
  endfunction

  // ----------------------------------------------------------------- tests
  task automatic test_one_byte_streams();
    octet_t vals [3];
    vals = '{8'h00, 8'hFF, rlbe_pkg::END_MARK};
    foreach (vals[i]) begin
      stream_q = '{vals[i]};
      send_stream();
    end
  endtask

  task automatic test_short_patterns();
    // run, literals, run, then a lone byte as the end of stream
    stream_q = '{8'h11, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h55, 8'h55, 8'hAA};
    send_stream();
    // stream that ends inside a run
    stream_q = '{8'h7F, 8'h7F};
    send_stream();
    // stream of literals only
    stream_q = '{8'h01, 8'hFE};
    send_stream();
    stream_q = '{8'h5A, 8'h5A, 8'h5A, 8'hA5};
    send_stream();
  endtask

  task automatic test_block_limits();
    // literal store fills and flushes on its own, then a run one byte past a
    // full repeat block, then literals that must not absorb the leftover
    stream_q.delete();
    for (int i = 0; i <= BLOCK_MAX; i++) stream_q.push_back(octet_t'(i));
    add_run(octet_t'(BLOCK_MAX), BLOCK_MAX);
    stream_q.push_back(8'h3C);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    send_stream();
    wait_drain();
  endtask

  task automatic test_hold_off();
    // short runs so that every other item leaves a repeat block behind
    stream_q.delete();
    for (int k = 0; k < 12; k++) add_run(octet_t'(k * 13 + 1), 2);
    hold_req = 1'b1;
    send_stream();
    wait_drain();
  endtask

  task automatic test_random_streams(input int unsigned target);
    int unsigned sent;
    int unsigned kind;
    sent = 0;
    while (sent < target) begin
      stream_q.delete();
      repeat ($urandom_range(1, 8)) begin
        kind = $urandom_range(0, 79);
        if (kind < 36) begin
          add_run(fresh_byte(), $urandom_range(2, 6));
        end else if (kind < 64) begin
          add_literals($urandom_range(1, 8));
        end else if (kind < 79) begin
          // noise: either a random byte or one that extends the last run
          if (stream_q.size() != 0 && $urandom_range(0, 1) == 0)
            stream_q.push_back(stream_q[$]);
          else
            stream_q.push_back(octet_t'($urandom_range(0, 255)));
        end else begin
          add_run(fresh_byte(), $urandom_range(BLOCK_MAX - 3, BLOCK_MAX + 3));
        end
      end
      sent += stream_q.size();
      send_stream();
    end
  endtask

  task automatic test_quiet_finish();
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    test_random_streams(16);
  endtask

  // ------------------------------------------------------------------ main
  initial begin
    clear_encoder();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_one_byte_streams();
    test_short_patterns();
    test_block_limits();
    test_hold_off();
    test_random_streams(30);
    test_quiet_finish();

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_words.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/rlbe_pkg.sv
rtl/rlbe_dp.sv
rtl/rlbe_pack.sv
rtl/rlbe_ctrl.sv
rtl/run_length_byte_encoder.sv
tb/sv/tb.sv
